FILE: rtl/rpn_stack_calculator_assert.svh
// Assertion macros shared by the checker files of the RPN stack calculator.
// Depends on nothing; include by bare file name.
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH
// Implication checked on every edge outside reset.
`define RPN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RPN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/rpn_pkg.sv
// Package for the RPN stack calculator: widths, mode codes, state type.
// No dependencies.
package rpn_pkg;
    localparam int DataW = 32;
    localparam int ModeW = 3;
    localparam int DepthW = 7;
    localparam int StackDepthDefault = 64;

    typedef enum logic [2:0] {
        MODE_PUSH = 3'd0,
        MODE_ADD  = 3'd1,
        MODE_SUB  = 3'd2,
        MODE_MUL  = 3'd3,
        MODE_DIV  = 3'd4,
        MODE_MOD  = 3'd5,
        MODE_POP  = 3'd6,
        MODE_UNK  = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_B,
        ST_RD_A,
        ST_EXEC,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic is_mod;
    } div_ctl_t;

    typedef struct packed {
        logic done;
    } div_sts_t;
endpackage

FILE: rtl/rpn_if.sv
// Valid/ready stream interfaces for the RPN stack calculator.
// Depends on rpn_pkg.
interface rpn_in_if;
    logic                      valid;
    logic                      ready;
    logic [rpn_pkg::ModeW-1:0] mode;
    logic signed [rpn_pkg::DataW-1:0] operand;
    modport source (output valid, mode, operand, input ready);
    modport sink (input valid, mode, operand, output ready);
endinterface

interface rpn_out_if;
    logic                      valid;
    logic                      ready;
    logic signed [rpn_pkg::DataW-1:0] result_value;
    logic                      underflow;
    logic                      overflow;
    logic                      zero_divisor;
    logic                      unknown_command;
    logic                      saturated;
    logic [rpn_pkg::DepthW-1:0] stack_depth;
    modport source (output valid, result_value, underflow, overflow, zero_divisor,
                    unknown_command, saturated, stack_depth, input ready);
    modport sink (input valid, result_value, underflow, overflow, zero_divisor,
                  unknown_command, saturated, stack_depth, output ready);
endinterface

FILE: rtl/rpn_divider.sv
// Radix-2 restoring signed divider, one quotient bit per cycle.
// Depends on rpn_pkg. Division: (a<<16)/b saturated; mod: a%b truncating.
module rpn_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rpn_pkg::div_ctl_t                 ctl,
    input  logic signed [rpn_pkg::DataW-1:0]  a,
    input  logic signed [rpn_pkg::DataW-1:0]  b,
    output rpn_pkg::div_sts_t                 sts,
    output logic signed [rpn_pkg::DataW-1:0]  res,
    output logic                              sat
);
    localparam int NumW = 48;
    logic [NumW-1:0] num_reg, num_next;
    logic [32:0]     rem_reg, rem_next;
    logic [31:0]     den_reg, den_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next, done_reg, done_next;
    logic            neg_q_reg, neg_q_next, neg_r_reg, neg_r_next, mod_reg, mod_next;
    logic [31:0]     abs_a, abs_b;
    logic [32:0]     trial;
    logic [NumW:0]   q_signed;
    logic [32:0]     r_signed;

    assign abs_a = a[31] ? (~a + 32'd1) : a;
    assign abs_b = b[31] ? (~b + 32'd1) : b;
    assign trial = {rem_reg[31:0], num_reg[NumW-1]} - {1'b0, den_reg};

    // The dividend magnitude sits at the top of the shift window: divide shifts
    // all 48 bits (quotient fills the window), mod stops after the 32 dividend bits.
    always_comb
    begin
        num_next = num_reg; rem_next = rem_reg; den_next = den_reg; cnt_next = cnt_reg;
        busy_next = busy_reg; done_next = 1'b0; neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg; mod_next = mod_reg;
        if (ctl.start)
        begin
            num_next = {abs_a, 16'd0};
            rem_next = '0;
            den_next = abs_b;
            cnt_next = ctl.is_mod ? 6'd32 : 6'd48;
            busy_next = 1'b1;
            neg_q_next = a[31] ^ b[31];
            neg_r_next = a[31];
            mod_next = ctl.is_mod;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial;
                num_next = {num_reg[NumW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], num_reg[NumW-1]};
                num_next = {num_reg[NumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next; den_reg <= den_next; cnt_reg <= cnt_next;
        neg_q_reg <= neg_q_next; neg_r_reg <= neg_r_next; mod_reg <= mod_next;
    end

    assign q_signed = neg_q_reg ? (~{1'b0, num_reg} + 49'd1) : {1'b0, num_reg};
    assign r_signed = neg_r_reg ? (~rem_reg + 33'd1) : rem_reg;

    always_comb
    begin
        sat = 1'b0;
        if (mod_reg)
            res = r_signed[31:0];
        else if (!neg_q_reg && num_reg > 48'h7FFFFFFF)
        begin
            res = 32'sh7FFFFFFF; sat = 1'b1;
        end
        else if (neg_q_reg && num_reg > 48'h80000000)
        begin
            res = 32'sh80000000; sat = 1'b1;
        end
        else
            res = q_signed[31:0];
    end

    assign sts.done = done_reg;
endmodule

FILE: rtl/rpn_stack_calculator.sv
// RPN stack calculator top level: stack memory, sequencer, ALU, output register.
// Depends on rpn_pkg, rpn_if and rpn_divider.
//
// One item at a time. The sequencer goes from idle straight to output for push
// and unknown command, through read, finish and output for pop, and through two
// reads of the stack memory (each registered), an execute step and a finish step
// for add/sub/mul and on a zero divisor. Divide and remainder run in the radix-2
// divider between execute and finish; it retires one bit per cycle (48 steps for
// divide, 32 for remainder) and then reports done. The result sits in an output
// register; a waiting result holds the sequencer in its output state until it
// is transferred, and the next item is taken the cycle after. The stack memory
// has no reset: only entries below the stack pointer are used. Stack depth is
// the STACK_DEPTH parameter (2..1024); stack_depth shows the count modulo 128.
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = rpn_pkg::StackDepthDefault
) (
    input logic clk,
    input logic rst_n,
    rpn_in_if.sink    in_ch,
    rpn_out_if.source out_ch
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    logic signed [31:0] mem [STACK_DEPTH];
    logic signed [31:0] rd_data;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    rpn_pkg::state_t state_reg, state_next;
    logic [SPW-1:0]  sp_reg, sp_next;
    logic [2:0]      mode_reg, mode_next;
    logic signed [31:0] a_reg, a_next, b_reg, b_next;
    logic signed [31:0] res_reg, res_next;
    logic uf_reg, uf_next, ov_reg, ov_next, zd_reg, zd_next, uk_reg, uk_next;
    logic sat_reg, sat_next;
    logic ovalid_reg, ovalid_next;
    logic signed [63:0] prod_reg;
    logic signed [32:0] sum;
    logic signed [63:0] mq;
    rpn_pkg::div_ctl_t div_ctl;
    rpn_pkg::div_sts_t div_sts;
    logic signed [31:0] div_res;
    logic div_sat;

    rpn_divider u_div (
        .clk(clk), .rst_n(rst_n), .ctl(div_ctl), .a(a_reg), .b(b_reg),
        .sts(div_sts), .res(div_res), .sat(div_sat)
    );

    // Memory: registered read, one write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk)
        prod_reg <= a_reg * b_reg;

    assign mq = prod_reg >>> 16;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rpn_pkg::ST_IDLE:
                if (in_ch.valid && in_ch.ready)
                begin
                    unique case (rpn_pkg::mode_t'(in_ch.mode))
                        rpn_pkg::MODE_PUSH, rpn_pkg::MODE_UNK: state_next = rpn_pkg::ST_OUT;
                        default: state_next = rpn_pkg::ST_RD_B;
                    endcase
                end
            rpn_pkg::ST_RD_B:
                state_next = (mode_reg == rpn_pkg::MODE_POP) ? rpn_pkg::ST_FIN
                                                             : rpn_pkg::ST_RD_A;
            rpn_pkg::ST_RD_A: state_next = rpn_pkg::ST_EXEC;
            rpn_pkg::ST_EXEC:
                // A zero divisor skips the divider and goes straight to finish
                state_next = ((mode_reg == rpn_pkg::MODE_DIV || mode_reg == rpn_pkg::MODE_MOD)
                              && !zd_reg) ? rpn_pkg::ST_DIV : rpn_pkg::ST_FIN;
            rpn_pkg::ST_DIV: if (div_sts.done) state_next = rpn_pkg::ST_FIN;
            rpn_pkg::ST_FIN: state_next = rpn_pkg::ST_OUT;
            rpn_pkg::ST_OUT: if (!ovalid_reg || out_ch.ready) state_next = rpn_pkg::ST_IDLE;
            default: state_next = rpn_pkg::ST_IDLE;
        endcase
    end

    // Datapath: read top entries, compute, write back and load output register.
    always_comb
    begin
        sp_next = sp_reg; mode_next = mode_reg;
        a_next = a_reg; b_next = b_reg; res_next = res_reg;
        uf_next = uf_reg; ov_next = ov_reg; zd_next = zd_reg; uk_next = uk_reg;
        sat_next = sat_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;
        rd_addr = (sp_reg == '0) ? '0 : AW'(sp_reg - SPW'(1));
        wr_en = 1'b0; wr_addr = sp_reg[AW-1:0]; wr_data = res_reg;
        div_ctl = '0;
        sum = '0;
        unique case (state_reg)
            rpn_pkg::ST_IDLE:
                if (in_ch.valid && in_ch.ready)
                begin
                    mode_next = in_ch.mode;
                    uf_next = 1'b0; ov_next = 1'b0; zd_next = 1'b0; uk_next = 1'b0;
                    sat_next = 1'b0; res_next = '0; a_next = '0; b_next = '0;
                    if (in_ch.mode == rpn_pkg::MODE_PUSH)
                    begin
                        res_next = in_ch.operand;
                        if (sp_reg < SPW'(STACK_DEPTH))
                        begin
                            wr_en = 1'b1; wr_data = in_ch.operand;
                            sp_next = sp_reg + SPW'(1);
                        end
                        else
                            ov_next = 1'b1;
                    end
                    else if (in_ch.mode == rpn_pkg::MODE_UNK)
                        uk_next = 1'b1;
                    else if (sp_reg != '0)
                        sp_next = sp_reg - SPW'(1);
                    else
                        uf_next = 1'b1;
                end
            rpn_pkg::ST_RD_B:
            begin
                if (!uf_reg) b_next = rd_data;
                if (mode_reg == rpn_pkg::MODE_POP)
                    res_next = uf_reg ? '0 : rd_data;
                else if ((mode_reg == rpn_pkg::MODE_DIV || mode_reg == rpn_pkg::MODE_MOD)
                         && (uf_reg || rd_data == '0))
                    ; // zero divisor: keep the dividend on the stack
                else if (sp_reg != '0)
                    sp_next = sp_reg - SPW'(1);
                else
                    uf_next = 1'b1;
            end
            rpn_pkg::ST_RD_A:
                if ((mode_reg == rpn_pkg::MODE_DIV || mode_reg == rpn_pkg::MODE_MOD)
                    && b_reg == '0)
                    zd_next = 1'b1;
                else
                    a_next = (uf_reg) ? '0 : rd_data;
            rpn_pkg::ST_EXEC:
                if ((mode_reg == rpn_pkg::MODE_DIV || mode_reg == rpn_pkg::MODE_MOD) && !zd_reg)
                begin
                    div_ctl.start = 1'b1;
                    div_ctl.is_mod = (mode_reg == rpn_pkg::MODE_MOD);
                end
            rpn_pkg::ST_DIV:
                if (div_sts.done)
                begin
                    res_next = div_res; sat_next = div_sat;
                end
            rpn_pkg::ST_FIN:
            begin
                if (mode_reg == rpn_pkg::MODE_ADD || mode_reg == rpn_pkg::MODE_SUB)
                begin
                    sum = (mode_reg == rpn_pkg::MODE_ADD) ? (a_reg + b_reg) : (a_reg - b_reg);
                    if (sum[32] != sum[31])
                    begin
                        res_next = sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
                        sat_next = 1'b1;
                    end
                    else
                        res_next = sum[31:0];
                end
                else if (mode_reg == rpn_pkg::MODE_MUL)
                begin
                    if (mq > 64'sh7FFFFFFF)
                    begin
                        res_next = 32'sh7FFFFFFF; sat_next = 1'b1;
                    end
                    else if (mq < -64'sh80000000)
                    begin
                        res_next = 32'sh80000000; sat_next = 1'b1;
                    end
                    else
                        res_next = mq[31:0];
                end
                else if (zd_reg)
                    res_next = '0;
            end
            rpn_pkg::ST_OUT:
                if (!ovalid_reg || out_ch.ready)
                begin
                    ovalid_next = 1'b1;
                    if (mode_reg != rpn_pkg::MODE_PUSH && mode_reg != rpn_pkg::MODE_POP
                        && mode_reg != rpn_pkg::MODE_UNK && !zd_reg)
                    begin
                        wr_en = 1'b1; wr_data = res_reg;
                        sp_next = sp_reg + SPW'(1);
                    end
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpn_pkg::ST_IDLE;
            sp_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg <= sp_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next; a_reg <= a_next; b_reg <= b_next;
        res_reg <= res_next; uf_reg <= uf_next; ov_reg <= ov_next; zd_reg <= zd_next;
        uk_reg <= uk_next; sat_reg <= sat_next;
    end

    // Output register: hold until transferred.
    logic signed [31:0] ores_reg;
    logic [6:0] odep_reg;
    logic [4:0] oflg_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == rpn_pkg::ST_OUT && (!ovalid_reg || out_ch.ready))
        begin
            ores_reg <= res_reg;
            oflg_reg <= {uf_reg, ov_reg, zd_reg, uk_reg, sat_reg};
            odep_reg <= 7'(sp_next);
        end
    end

    assign in_ch.ready = (state_reg == rpn_pkg::ST_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.result_value = ores_reg;
    assign out_ch.underflow = oflg_reg[4];
    assign out_ch.overflow = oflg_reg[3];
    assign out_ch.zero_divisor = oflg_reg[2];
    assign out_ch.unknown_command = oflg_reg[1];
    assign out_ch.saturated = oflg_reg[0];
    assign out_ch.stack_depth = odep_reg;
endmodule

FILE: rtl/rpn_checker.sv
// Port-level checker for the RPN stack calculator, bound to the top level.
// Depends on rpn_stack_calculator_assert.svh.
`include "rpn_stack_calculator_assert.svh"
module rpn_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [6:0] depth,
    input logic uf,
    input logic ov,
    input logic uk,
    input logic zd
);
    `RPN_ASSERT_NXT(a_one_busy, clk, rst_n, in_valid && in_ready, !in_ready)
    `RPN_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(depth))
    `RPN_ASSERT_IMP(a_uk_alone, clk, rst_n, out_valid && uk, !uf && !ov && !zd)
    `RPN_ASSERT_IMP(a_ov_full, clk, rst_n, out_valid && ov, depth != 7'd0)
endmodule

bind rpn_stack_calculator rpn_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .depth(out_ch.stack_depth),
    .uf(out_ch.underflow), .ov(out_ch.overflow), .uk(out_ch.unknown_command),
    .zd(out_ch.zero_divisor)
);
